FILE: rtl/ptq_pkg.sv
// Shared types, constants and codes for the periodic timer queue.
`timescale 1ns / 1ps
package ptq_pkg;
	localparam int Capacity = 16;
	localparam int IdBits = 8;
	localparam int TimeBits = 32;
	localparam int IvlBits = 24;
	localparam int SlotBits = $clog2(Capacity);
	localparam int CountBits = $clog2(Capacity + 1);

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SCHED = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	localparam logic [2:0] K_FIRED = 3'd0;
	localparam logic [2:0] K_SCHED = 3'd1;
	localparam logic [2:0] K_FULL = 3'd2;
	localparam logic [2:0] K_CANCEL = 3'd3;
	localparam logic [2:0] K_TICK = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic [23:0] delay_ms;
		logic repeat_req;
		logic [23:0] interval_ms;
		logic [7:0] cancel_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] task_id;
		logic last;
	} out_item_t;

	// One heap entry: due time, interval, repeat flag, id.
	typedef struct packed {
		logic [TimeBits-1:0] due;
		logic [IvlBits-1:0] ivl;
		logic rep;
		logic [IdBits-1:0] id;
	} entry_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic latch_in;     // capture the input item
		logic tick_now;     // advance time by one
		logic mark_cancel;  // set cancel mark of the latched id
		logic push_new;     // start push of scheduled entry
		logic pop_start;    // remove root, start sift down
		logic push_rep;     // push the popped periodic entry
		logic sift_step;    // one step of the running sift
		logic emit;         // drive a result
		logic [2:0] kind;
		logic id_sel;       // 1: popped id, 0: new id (zero unless a schedule result)
		logic last;
		logic clr_pops;
	} cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic full;
		logic root_due;     // count > 0, root due, pops below bound
		logic sift_busy;
		logic pop_cancelled;
		logic pop_rep;
	} stat_t;
endpackage

FILE: rtl/ptq_datapath.sv
// Heap storage, time, id counter, cancel marks and sift engine.
`timescale 1ns / 1ps
module ptq_datapath (
	input logic clk,
	input logic arst_n,
	input ptq_pkg::in_item_t in_item,
	input ptq_pkg::cmd_t cmd,
	output ptq_pkg::stat_t stat,
	output ptq_pkg::out_item_t result_d
);
	ptq_pkg::entry_t heap_q [ptq_pkg::Capacity];
	logic [ptq_pkg::CountBits-1:0] count_q;
	logic [ptq_pkg::TimeBits-1:0] now_q;
	logic [ptq_pkg::IdBits-1:0] idc_q, newid_q;
	logic [(1 << ptq_pkg::IdBits)-1:0] marks_q;
	ptq_pkg::in_item_t item_q;
	ptq_pkg::entry_t popped_q;
	logic [ptq_pkg::CountBits-1:0] pops_q;
	logic up_q, down_q;
	logic [ptq_pkg::SlotBits-1:0] idx_q;

	logic [ptq_pkg::SlotBits:0] lc, rc;
	logic [ptq_pkg::SlotBits-1:0] par, chi;
	logic l_ok, r_ok, go_up, go_down;
	logic [ptq_pkg::IvlBits-1:0] ivl_new, ivl_rep;
	ptq_pkg::entry_t new_e, rep_e;

	always_comb begin
		lc = {idx_q, 1'b1};
		rc = lc + 1'b1;
		par = ptq_pkg::SlotBits'((idx_q - 1'b1) >> 1);
		l_ok = {1'b0, lc} < (ptq_pkg::SlotBits + 2)'(count_q);
		r_ok = {1'b0, rc} < (ptq_pkg::SlotBits + 2)'(count_q);
		chi = lc[ptq_pkg::SlotBits-1:0];
		if (r_ok && heap_q[rc[ptq_pkg::SlotBits-1:0]].due < heap_q[chi].due)
			chi = rc[ptq_pkg::SlotBits-1:0];
		go_up = up_q && idx_q != '0 && heap_q[idx_q].due < heap_q[par].due;
		go_down = down_q && l_ok && heap_q[chi].due < heap_q[idx_q].due;
		ivl_new = item_q.interval_ms == '0 ? ptq_pkg::IvlBits'(1) : item_q.interval_ms;
		ivl_rep = popped_q.ivl == '0 ? ptq_pkg::IvlBits'(1) : popped_q.ivl;
		new_e.due = now_q + ptq_pkg::TimeBits'(item_q.delay_ms);
		new_e.ivl = ivl_new;
		new_e.rep = item_q.repeat_req;
		new_e.id = idc_q;
		rep_e = popped_q;
		rep_e.due = now_q + ptq_pkg::TimeBits'(ivl_rep);
	end

	always_comb begin
		stat.op = item_q.operation;
		stat.full = count_q == ptq_pkg::CountBits'(ptq_pkg::Capacity);
		stat.root_due = count_q != '0 && heap_q[0].due <= now_q
			&& pops_q != ptq_pkg::CountBits'(ptq_pkg::Capacity);
		stat.sift_busy = go_up || go_down;
		stat.pop_cancelled = marks_q[popped_q.id];
		stat.pop_rep = popped_q.rep;
		result_d.kind = cmd.kind;
		result_d.last = cmd.last;
		result_d.task_id = '0;
		if (cmd.id_sel)
			result_d.task_id = 8'(popped_q.id);
		else if (cmd.kind == ptq_pkg::K_SCHED)
			result_d.task_id = 8'(newid_q);
	end

	// Heap slots hold no reset; only slots below the count are read.
	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			item_q <= in_item;
		if (cmd.push_new)
			heap_q[count_q[ptq_pkg::SlotBits-1:0]] <= new_e;
		else if (cmd.push_rep)
			heap_q[count_q[ptq_pkg::SlotBits-1:0]] <= rep_e;
		else if (cmd.pop_start) begin
			popped_q <= heap_q[0];
			heap_q[0] <= heap_q[ptq_pkg::SlotBits'(count_q - 1'b1)];
		end else if (cmd.sift_step && go_up) begin
			heap_q[idx_q] <= heap_q[par];
			heap_q[par] <= heap_q[idx_q];
		end else if (cmd.sift_step && go_down) begin
			heap_q[idx_q] <= heap_q[chi];
			heap_q[chi] <= heap_q[idx_q];
		end
		if (cmd.push_new)
			newid_q <= idc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			now_q <= '0;
			idc_q <= ptq_pkg::IdBits'(1);
			marks_q <= '0;
			pops_q <= '0;
			up_q <= 1'b0;
			down_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.tick_now)
				now_q <= now_q + 1'b1;
			if (cmd.clr_pops)
				pops_q <= '0;
			if (cmd.mark_cancel)
				marks_q[item_q.cancel_id[ptq_pkg::IdBits-1:0]] <= 1'b1;
			if (cmd.push_new || cmd.push_rep) begin
				idx_q <= count_q[ptq_pkg::SlotBits-1:0];
				count_q <= count_q + 1'b1;
				up_q <= 1'b1;
				down_q <= 1'b0;
			end else if (cmd.pop_start) begin
				idx_q <= '0;
				count_q <= count_q - 1'b1;
				pops_q <= pops_q + 1'b1;
				up_q <= 1'b0;
				down_q <= 1'b1;
			end else if (cmd.sift_step) begin
				if (go_up)
					idx_q <= par;
				else if (go_down)
					idx_q <= chi;
				else begin
					up_q <= 1'b0;
					down_q <= 1'b0;
				end
			end
			if (cmd.push_new) begin
				idc_q <= idc_q + 1'b1;
				marks_q[idc_q] <= 1'b0;
			end
		end
	end
endmodule

FILE: rtl/ptq_ctrl.sv
// Sequencing state machine for the timer queue.
`timescale 1ns / 1ps
module ptq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ptq_pkg::stat_t stat,
	output ptq_pkg::cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_SIFT_DN = 7'b0001000,
		S_JUDGE = 7'b0010000,
		S_SIFT_UP = 7'b0100000,
		S_SCHED_UP = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		busy = state_q != S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					ptq_pkg::OP_TICK: begin
						cmd.tick_now = 1'b1;
						cmd.clr_pops = 1'b1;
						state_d = S_CHECK;
					end
					ptq_pkg::OP_SCHED: begin
						if (stat.full) begin
							cmd.emit = 1'b1;
							cmd.kind = ptq_pkg::K_FULL;
							cmd.last = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.push_new = 1'b1;
							state_d = S_SCHED_UP;
						end
					end
					ptq_pkg::OP_CANCEL: begin
						cmd.mark_cancel = 1'b1;
						cmd.emit = 1'b1;
						cmd.kind = ptq_pkg::K_CANCEL;
						cmd.last = 1'b1;
						state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCHED_UP: begin
				cmd.sift_step = 1'b1;
				if (!stat.sift_busy) begin
					cmd.emit = 1'b1;
					cmd.kind = ptq_pkg::K_SCHED;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CHECK: begin
				if (stat.root_due) begin
					cmd.pop_start = 1'b1;
					state_d = S_SIFT_DN;
				end else begin
					cmd.emit = 1'b1;
					cmd.kind = ptq_pkg::K_TICK;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SIFT_DN: begin
				cmd.sift_step = 1'b1;
				if (!stat.sift_busy)
					state_d = S_JUDGE;
			end
			S_JUDGE: begin
				if (stat.pop_cancelled)
					state_d = S_CHECK;
				else begin
					cmd.emit = 1'b1;
					cmd.kind = ptq_pkg::K_FIRED;
					cmd.id_sel = 1'b1;
					if (stat.pop_rep) begin
						cmd.push_rep = 1'b1;
						state_d = S_SIFT_UP;
					end else
						state_d = S_CHECK;
				end
			end
			S_SIFT_UP: begin
				cmd.sift_step = 1'b1;
				if (!stat.sift_busy)
					state_d = S_CHECK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

FILE: rtl/periodic_timer_queue_core.sv
// Top level of the periodic timer queue: controller, datapath, result register.
`timescale 1ns / 1ps
//  channel   handshake            payload
//  command   start & !busy        cmd_item   (in_item_t)
//  result    done (one cycle)     result     (out_item_t)
//
// Cancel and queue_full are answered from the decode state through the result register.
// Schedule pushes the new entry and sifts it up (one cycle per sift level).
// A tick advances time, then per due entry pops the root and sifts it down;
// a periodic entry that is not cancelled is pushed back and sifted up.
// Reset at once clears time, count and cancel marks and sets the id counter
// to one; heap slots are left as they are. The receiver cannot stall: each
// result shows for one cycle.
module periodic_timer_queue_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ptq_pkg::in_item_t cmd_item,
	output logic done,
	output ptq_pkg::out_item_t result
);
	ptq_pkg::cmd_t cmd;
	ptq_pkg::stat_t stat;
	ptq_pkg::out_item_t result_d;
	logic ctrl_busy;

	ptq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(ctrl_busy),
		.stat(stat), .cmd(cmd)
	);

	ptq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(cmd_item), .cmd(cmd),
		.stat(stat), .result_d(result_d)
	);

	// Hold busy while a non-final result sits in the output register.
	assign busy = ctrl_busy || (done && !result.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			result <= result_d;
	end
endmodule
